### rtl/core/sttag_pkg.sv
// Shared types, constants and swizzle functions for the supertile texel address generator.
// No dependencies; every other file in rtl/core depends on this package.
`timescale 1ns / 1ps

package sttag_pkg;

	localparam int unsigned ADDR_W         = 24;
	localparam int unsigned COORD_W        = 12;
	localparam int unsigned DIM_W          = 13;
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 13;
	localparam int unsigned ST_LOG2        = 6;
	localparam int unsigned ST_DIM         = 64;
	localparam int unsigned COORD_BITS_DEF = 12;

	// swizzled-x and swizzled-y bit positions inside the 24-bit index
	localparam logic [ADDR_W-1:0]  X_MASK = 24'hFFF393;
	localparam logic [COORD_W-1:0] Y_MASK = 12'hC6C;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH = 3'd0,
		REG_RECT_X     = 3'd1,
		REG_RECT_Y     = 3'd2,
		REG_RECT_W     = 3'd3,
		REG_RECT_H     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]   dest_width;
		logic [COORD_W-1:0] rect_x;
		logic [COORD_W-1:0] rect_y;
		logic [DIM_W-1:0]   rect_w;
		logic [DIM_W-1:0]   rect_h;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] index;
		logic              last;
		logic              oor;
	} res_t;

	// in-supertile x bits go to x1x0 -> 1:0, x2 -> 4, x5..x3 -> 9:7, supertile column above
	function automatic logic [ADDR_W-1:0] swz_x(input logic [ADDR_W-1:0] x);
		return (x & 24'h03) | ((x & 24'h04) << 2) | ((x & 24'h38) << 4) |
			((x & ~24'h3f) << 6);
	endfunction

	function automatic logic [COORD_W-1:0] swz_y(input logic [COORD_W-1:0] y);
		return ((y & 12'h03) << 2) | ((y & 12'h0c) << 3) | ((y & 12'h30) << 6);
	endfunction

	// one supertile row: width aligned up to the supertile size, times 64
	function automatic logic [ADDR_W-1:0] row_stride(input logic [DIM_W-1:0] w);
		logic [DIM_W:0] a;
		a = ({1'b0, w} + (DIM_W+1)'(ST_DIM - 1)) & ~(DIM_W+1)'(ST_DIM - 1);
		return swz_x({{(ADDR_W-DIM_W-1){1'b0}}, a});
	endfunction

endpackage

### rtl/core/sttag_cfg_regs.sv
// Configuration register file for the supertile texel address generator.
// Depends on sttag_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module sttag_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sttag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sttag_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sttag_pkg::cfg_t                    cfg
);
	import sttag_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_width <= DIM_W'(ST_DIM);
			cfg_q.rect_x     <= '0;
			cfg_q.rect_y     <= '0;
			cfg_q.rect_w     <= DIM_W'(1);
			cfg_q.rect_h     <= DIM_W'(1);
		end else if (wr_en) begin
			unique case (cfg_index)
				REG_DEST_WIDTH: cfg_q.dest_width <= cfg_data;
				REG_RECT_X:     cfg_q.rect_x     <= cfg_data[COORD_W-1:0];
				REG_RECT_Y:     cfg_q.rect_y     <= cfg_data[COORD_W-1:0];
				REG_RECT_W:     cfg_q.rect_w     <= cfg_data;
				REG_RECT_H:     cfg_q.rect_h     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/sttag_addr_step.sv
// Rectangle walk state and per-texel index computation.
// Depends on sttag_pkg for swizzle functions, masks and the cfg_t / res_t bundles.
`timescale 1ns / 1ps

module sttag_addr_step #(
	parameter int unsigned COORD_BITS = sttag_pkg::COORD_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  sttag_pkg::cfg_t cfg,
	output sttag_pkg::res_t res
);
	import sttag_pkg::*;

	localparam logic [COORD_W+2:0] LIM = (COORD_W+3)'((1 << COORD_BITS) - 1);

	logic [DIM_W-1:0]   col_q, row_q;
	logic [ADDR_W-1:0]  x_q, base_q;
	logic [COORD_W-1:0] y_q;

	logic               start, row_end, last;
	logic [DIM_W-1:0]   w, h;
	logic [DIM_W:0]     col_inc, row_inc;
	logic [ADDR_W-1:0]  stride, start_base, xs, base, x_row, x_next;
	logic [COORD_W-1:0] ys, y_next;
	logic [ADDR_W+1:0]  prod;
	logic [COORD_W+1:0] cx, cy;

	assign start  = (col_q == '0) && (row_q == '0);
	assign stride = row_stride(cfg.dest_width);
	// supertile row of rect_y times the row stride
	assign prod = {{ADDR_W-4{1'b0}}, cfg.rect_y[COORD_W-1:ST_LOG2]} *
		{2'b0, stride};
	assign start_base = prod[ADDR_W-1:0];

	assign x_row = swz_x({{(ADDR_W-COORD_W){1'b0}}, cfg.rect_x});
	assign xs    = start ? x_row : x_q;
	assign ys    = start ? swz_y(cfg.rect_y) : y_q;
	assign base  = start ? start_base : base_q;

	assign w       = (cfg.rect_w == '0) ? DIM_W'(1) : cfg.rect_w;
	assign h       = (cfg.rect_h == '0) ? DIM_W'(1) : cfg.rect_h;
	assign col_inc = {1'b0, col_q} + (DIM_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (DIM_W+1)'(1);
	assign row_end = col_inc >= {1'b0, w};
	assign last    = row_end && (row_inc >= {1'b0, h});

	assign cx = {2'b0, cfg.rect_x} + {1'b0, col_q};
	assign cy = {2'b0, cfg.rect_y} + {1'b0, row_q};

	// masked increments: borrow ripples through the gaps of the swizzle
	assign x_next = (xs - X_MASK) & X_MASK;
	assign y_next = (ys - Y_MASK) & Y_MASK;

	assign res.index = base + {{(ADDR_W-COORD_W){1'b0}}, ys} + xs;
	assign res.last  = last;
	assign res.oor   = ({1'b0, cx} > LIM) || ({1'b0, cy} > LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			base_q <= '0;
		end else if (advance) begin
			if (last) begin
				col_q  <= '0;
				row_q  <= '0;
				x_q    <= xs;
				y_q    <= ys;
				base_q <= base;
			end else if (row_end) begin
				col_q  <= '0;
				row_q  <= row_inc[DIM_W-1:0];
				x_q    <= x_row;
				y_q    <= y_next;
				// add a supertile row when the in-tile y wraps
				base_q <= (y_next == '0) ? base + stride : base;
			end else begin
				col_q  <= col_inc[DIM_W-1:0];
				x_q    <= x_next;
				y_q    <= ys;
				base_q <= base;
			end
		end
	end

endmodule

### rtl/core/supertile_texel_address_gen.sv
// Top level of the supertile texel address generator: input register, step logic, output register.
// Depends on sttag_pkg, sttag_cfg_regs and sttag_addr_step.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   src     | in        | src_valid / src_stall     | texel_in
//   dst     | out       | dst_valid / dst_stall     | texel_index, texel_out, last_texel,
//           |           |                           | out_of_range
//   cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One texel per cycle sustained while dst is not stalled; an accepted texel goes through the
// input register and then the result register before its dst transaction.
// The rectangle walk state advances when a texel moves into the result register.
// Reset clears the walk counters and loads register defaults; cfg_ready is always high.
// src_stall rises only when both registers are full and dst is stalled.
`timescale 1ns / 1ps

module supertile_texel_address_gen #(
	parameter int unsigned COORD_BITS = sttag_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  logic [sttag_pkg::DATA_W-1:0]     texel_in,
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output logic [sttag_pkg::ADDR_W-1:0]     texel_index,
	output logic [sttag_pkg::DATA_W-1:0]     texel_out,
	output logic                             last_texel,
	output logic                             out_of_range,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sttag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sttag_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sttag_pkg::*;

	cfg_t              cfg;
	res_t              res, res_q;
	logic              valid_s1, out_valid_q;
	logic [DATA_W-1:0] texel_s1, texel_q;
	logic              accept, advance;

	sttag_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sttag_addr_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance   = valid_s1 && (!out_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!dst_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			texel_s1 <= texel_in;
		if (advance) begin
			texel_q <= texel_s1;
			res_q   <= res;
		end
	end

	assign dst_valid    = out_valid_q;
	assign texel_index  = res_q.index;
	assign texel_out    = texel_q;
	assign last_texel   = res_q.last;
	assign out_of_range = res_q.oor;

endmodule

### rtl/core/sttag_checker.sv
// Port-level checks for the supertile texel address generator, bound to the top level.
// Depends on sttag_pkg for field widths.
`timescale 1ns / 1ps

module sttag_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         src_valid,
	input logic                         src_stall,
	input logic                         dst_valid,
	input logic                         dst_stall,
	input logic [sttag_pkg::ADDR_W-1:0] texel_index,
	input logic [sttag_pkg::DATA_W-1:0] texel_out,
	input logic                         cfg_valid,
	input logic                         cfg_ready
);

	// hold a stalled result
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(texel_index) && $stable(texel_out))
		else $error("dst transaction changed while stalled");

	// backpressure only comes from a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall)
		else $error("src stalled without dst backpressure");

	// an accepted texel reaches dst once the output register is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) ##1 (!dst_valid || !dst_stall) |=> dst_valid)
		else $error("accepted texel did not reach dst");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind supertile_texel_address_gen sttag_checker u_sttag_checker (.*);
